// ===== hdl/vtgd_pkg.sv =====
// Shared types, codes and helpers for the vector tile geometry decoder.
package vtgd_pkg;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_POINT  = 2'd1;
	localparam logic [1:0] KIND_TRUNC  = 2'd2;

	// Command ids that take parameter words
	localparam logic [2:0] CMD_MOVE = 3'd1;
	localparam logic [2:0] CMD_LINE = 3'd2;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ID_W    = 3;
	localparam int unsigned COUNT_W = 29;

	// Input word
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last_word;
	} item_t;

	// Result word
	typedef struct packed {
		logic [1:0]                kind;
		logic [ID_W-1:0]           cmd_id;
		logic [COUNT_W-1:0]        repeat_count;
		logic signed [WORD_W-1:0]  point_x;
		logic signed [WORD_W-1:0]  point_y;
	} result_t;

	// Classified operation passed from front to back; x and y still zigzag coded
	typedef struct packed {
		logic [1:0]         kind;
		logic [ID_W-1:0]    cmd_id;
		logic [COUNT_W-1:0] repeat_count;
		logic [WORD_W-1:0]  x_raw;
		logic [WORD_W-1:0]  y_raw;
	} op_t;

	// Queue status seen by the top level
	typedef struct packed {
		logic [1:0] count;
	} queue_status_t;

	// Zigzag decode: (n >> 1) xor -(n & 1)
	function automatic logic signed [WORD_W-1:0] unzigzag(input logic [WORD_W-1:0] n);
		unzigzag = signed'((n >> 1) ^ {WORD_W{n[0]}});
	endfunction

endpackage

// ===== hdl/vector_tile_geometry_decoder.sv =====
// Vector tile geometry decoder, top level.
// Takes one geometry word per cycle while full is low (header or zigzag-coded
// parameter) and gives header, point and truncation results. The front end
// classifies each word in the cycle it is accepted and writes an operation into a
// two-entry queue; the back end decodes it into an output register. A result passes
// through the queue register and then the output register, and words flow at one per
// cycle when pop stays high. full rises whenever the queue holds two operations;
// x words that do not end the list produce no result.
module vector_tile_geometry_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  vtgd_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output vtgd_pkg::result_t result
);

	logic                    front_ready;
	logic                    f_op_valid;
	vtgd_pkg::op_t           f_op;
	logic                    q_wr_ready;
	logic                    q_rd_valid;
	vtgd_pkg::op_t           q_rd_op;
	logic                    b_ready;
	vtgd_pkg::queue_status_t q_status;

	assign full = !front_ready;

	vtgd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (push),
		.item       (item),
		.op_ready   (q_wr_ready),
		.item_ready (front_ready),
		.op_valid   (f_op_valid),
		.op         (f_op)
	);

	vtgd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_op_valid),
		.wr_op    (f_op),
		.wr_ready (q_wr_ready),
		.rd_valid (q_rd_valid),
		.rd_op    (q_rd_op),
		.rd_ready (b_ready),
		.status   (q_status)
	);

	vtgd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (q_rd_valid),
		.op       (q_rd_op),
		.op_ready (b_ready),
		.empty    (empty),
		.result   (result),
		.pop      (pop)
	);

	// Back pressure only when the queue is full
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (q_status.count == 2'd2))
		else $error("full without a full queue");

	// Queue never overfills
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count != 2'd3)
		else $error("queue count out of range");

	// Point results carry no count
	a_point_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.kind == vtgd_pkg::KIND_POINT)) |-> (result.repeat_count == '0))
		else $error("point word with nonzero count");

	// Header results carry no coordinates
	a_header_xy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.kind == vtgd_pkg::KIND_HEADER))
			|-> ((result.point_x == '0) && (result.point_y == '0)))
		else $error("header word with coordinates");

endmodule

// ===== hdl/vtgd_front.sv =====
// Front end: tracks command/parameter position and classifies each word.
module vtgd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  vtgd_pkg::item_t item,
	input  logic            op_ready,
	output logic            item_ready,
	output logic            op_valid,
	output vtgd_pkg::op_t   op
);

	logic                             in_par_q;
	logic                             expect_y_q;
	logic [vtgd_pkg::COUNT_W-1:0]     points_left_q;
	logic [vtgd_pkg::ID_W-1:0]        cur_id_q;
	logic [vtgd_pkg::WORD_W-1:0]      x_raw_q;

	logic                             accept;
	logic [vtgd_pkg::ID_W-1:0]        hdr_id;
	logic [vtgd_pkg::COUNT_W-1:0]     hdr_count;
	logic                             hdr_params;
	logic [vtgd_pkg::COUNT_W-1:0]     left_dec;
	logic                             has_result;

	assign item_ready = op_ready;
	assign accept     = item_valid && item_ready;

	assign hdr_id     = item.word[vtgd_pkg::ID_W-1:0];
	assign hdr_count  = item.word[vtgd_pkg::WORD_W-1:vtgd_pkg::ID_W];
	assign hdr_params = ((hdr_id == vtgd_pkg::CMD_MOVE) || (hdr_id == vtgd_pkg::CMD_LINE))
		&& (hdr_count != '0);
	assign left_dec   = points_left_q - 1'b1;

	// Classify the current word into an operation
	always_comb begin
		has_result      = 1'b1;
		op.kind         = vtgd_pkg::KIND_HEADER;
		op.cmd_id       = cur_id_q;
		op.repeat_count = '0;
		op.x_raw        = '0;
		op.y_raw        = '0;
		if (!in_par_q) begin
			op.kind         = (hdr_params && item.last_word) ? vtgd_pkg::KIND_TRUNC
				: vtgd_pkg::KIND_HEADER;
			op.cmd_id       = hdr_id;
			op.repeat_count = hdr_count;
		end else if (!expect_y_q) begin
			// x word: result only when the list ends here
			has_result      = item.last_word;
			op.kind         = vtgd_pkg::KIND_TRUNC;
			op.repeat_count = points_left_q;
		end else begin
			op.x_raw = x_raw_q;
			op.y_raw = item.word;
			op.kind  = vtgd_pkg::KIND_POINT;
			if ((left_dec != '0) && item.last_word) begin
				op.kind         = vtgd_pkg::KIND_TRUNC;
				op.repeat_count = left_dec;
			end
		end
	end

	assign op_valid = accept && has_result;

	// Decoder position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_par_q      <= 1'b0;
			expect_y_q    <= 1'b0;
			points_left_q <= '0;
			cur_id_q      <= '0;
		end else if (accept) begin
			if (!in_par_q) begin
				cur_id_q      <= hdr_id;
				expect_y_q    <= 1'b0;
				in_par_q      <= hdr_params && !item.last_word;
				points_left_q <= (hdr_params && !item.last_word) ? hdr_count : '0;
			end else if (!expect_y_q) begin
				expect_y_q <= !item.last_word;
				if (item.last_word) begin
					in_par_q      <= 1'b0;
					points_left_q <= '0;
					cur_id_q      <= '0;
				end
			end else begin
				expect_y_q    <= 1'b0;
				points_left_q <= left_dec;
				if (left_dec == '0) begin
					in_par_q <= 1'b0;
				end
				if (item.last_word) begin
					in_par_q      <= 1'b0;
					points_left_q <= '0;
					cur_id_q      <= '0;
				end
			end
		end
	end

	// Held x parameter, raw
	always_ff @(posedge clk) begin
		if (accept && in_par_q && !expect_y_q) begin
			x_raw_q <= item.word;
		end
	end

endmodule

// ===== hdl/vtgd_queue.sv =====
// Two-entry operation queue between front and back.
module vtgd_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_valid,
	input  vtgd_pkg::op_t           wr_op,
	output logic                    wr_ready,
	output logic                    rd_valid,
	output vtgd_pkg::op_t           rd_op,
	input  logic                    rd_ready,
	output vtgd_pkg::queue_status_t status
);

	logic [1:0]    count_q;
	vtgd_pkg::op_t head_q;
	vtgd_pkg::op_t tail_q;
	logic          wr_en;
	logic          rd_en;

	assign wr_ready     = (count_q != 2'd2);
	assign rd_valid     = (count_q != 2'd0);
	assign rd_op        = head_q;
	assign wr_en        = wr_valid && wr_ready;
	assign rd_en        = rd_valid && rd_ready;
	assign status.count = count_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	// Entry storage: head is always the oldest
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (count_q == 2'd2) begin
				head_q <= tail_q;
				if (wr_en) begin
					tail_q <= wr_op;
				end
			end else if (wr_en) begin
				head_q <= wr_op;
			end
		end else if (wr_en) begin
			if (count_q == 2'd0) begin
				head_q <= wr_op;
			end else begin
				tail_q <= wr_op;
			end
		end
	end

endmodule

// ===== hdl/vtgd_back.sv =====
// Back end: zigzag decode and registered result word.
module vtgd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  vtgd_pkg::op_t     op,
	output logic              op_ready,
	output logic              empty,
	output vtgd_pkg::result_t result,
	input  logic              pop
);

	logic              valid_q;
	vtgd_pkg::result_t result_q;
	logic              take;

	assign op_ready = !valid_q || pop;
	assign take     = op_valid && op_ready;
	assign empty    = !valid_q;
	assign result   = result_q;

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op_ready) begin
			valid_q <= op_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			result_q.kind         <= op.kind;
			result_q.cmd_id       <= op.cmd_id;
			result_q.repeat_count <= op.repeat_count;
			result_q.point_x      <= vtgd_pkg::unzigzag(op.x_raw);
			result_q.point_y      <= vtgd_pkg::unzigzag(op.y_raw);
		end
	end

endmodule

// ===== tb/tb_vector_tile_geometry_decoder.sv =====
// Testbench for the vector tile geometry decoder: directed table, random lists, scoreboard.
`timescale 1ns / 1ps

module tb_vector_tile_geometry_decoder;

	localparam int unsigned N_RANDOM   = 2000;
	localparam int unsigned HOLD_LEN   = 400;
	localparam int unsigned TAIL_LEN   = 20;
	localparam int unsigned CYCLE_CAP  = 1000000;
	localparam int unsigned MAX_REPORT = 10;

	// One directed row; the typed result is used only when pinned is set
	typedef struct {
		logic [31:0]       w;
		bit                lst;
		bit                pinned;
		vtgd_pkg::result_t r;
	} row_t;

	// Typed expectation travelling with each offered word
	typedef struct {
		bit                pinned;
		vtgd_pkg::result_t r;
	} pin_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              pop = 1'b0;
	vtgd_pkg::item_t   item = '0;
	logic              full;
	logic              empty;
	vtgd_pkg::result_t result;

	// Decoder state mirror
	bit          in_params;
	logic [28:0] pts_left;
	bit          want_y;
	logic [31:0] held_x;
	logic [2:0]  cur_id;

	vtgd_pkg::result_t pending_results[$];
	pin_t              pinned_q[$];
	row_t              plan[$];
	int unsigned       sent = 0;
	int unsigned       fail_cnt = 0;
	int unsigned       cycles = 0;
	int unsigned       burst_left = 0;
	bit                hold_req = 0;
	bit                hold_done = 0;

	vector_tile_geometry_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #6 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void clear_decoder();
		in_params = 0;
		pts_left  = '0;
		want_y    = 0;
		held_x    = '0;
		cur_id    = '0;
	endfunction

	// Zigzag parameter to signed value
	function automatic logic [31:0] unfold(input logic [31:0] n);
		return {1'b0, n[31:1]} ^ {32{n[0]}};
	endfunction

	// Advance the decoder mirror by one word; returns 1 when a result is due
	function automatic bit decode_word(input vtgd_pkg::item_t it,
			output vtgd_pkg::result_t r);
		logic [2:0]  id;
		logic [28:0] cnt;
		r = '0;
		if (!in_params) begin
			id = it.word[2:0];
			cnt = it.word[31:3];
			cur_id = id;
			want_y = 0;
			held_x = '0;
			pts_left = '0;
			r.kind = vtgd_pkg::KIND_HEADER;
			r.cmd_id = id;
			r.repeat_count = cnt;
			if ((id == vtgd_pkg::CMD_MOVE || id == vtgd_pkg::CMD_LINE) && cnt != 0) begin
				if (it.last_word) begin
					r.kind = vtgd_pkg::KIND_TRUNC;
				end else begin
					in_params = 1;
					pts_left = cnt;
				end
			end
			return 1;
		end
		// x word: held until its y arrives
		if (!want_y) begin
			held_x = unfold(it.word);
			want_y = 1;
			if (it.last_word) begin
				r.kind = vtgd_pkg::KIND_TRUNC;
				r.cmd_id = cur_id;
				r.repeat_count = pts_left;
				clear_decoder();
				return 1;
			end
			return 0;
		end
		// y word completes a point
		want_y = 0;
		pts_left = pts_left - 1'b1;
		r.kind = vtgd_pkg::KIND_POINT;
		r.cmd_id = cur_id;
		r.point_x = held_x;
		r.point_y = unfold(it.word);
		if (pts_left == 0) begin
			in_params = 0;
			if (it.last_word)
				clear_decoder();
		end else if (it.last_word) begin
			r.kind = vtgd_pkg::KIND_TRUNC;
			r.repeat_count = pts_left;
			clear_decoder();
		end
		return 1;
	endfunction

	// Idle length: mostly none or short, a few long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] param_word();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $urandom;
		if (r < 85)
			return $urandom_range(0, 40);
		if (r < 93)
			return 32'hFFFF_FFFF - $urandom_range(0, 3);
		return 32'h8000_0000 ^ $urandom_range(0, 3);
	endfunction

	function automatic void add_row(input logic [31:0] w, input bit lst, input bit pinned,
			input logic [1:0] kind, input logic [2:0] id, input logic [28:0] cnt);
		row_t row;
		row.w = w;
		row.lst = lst;
		row.pinned = pinned;
		row.r = '0;
		row.r.kind = kind;
		row.r.cmd_id = id;
		row.r.repeat_count = cnt;
		plan.push_back(row);
	endfunction

	// Offer one word after a random gap and hold it until taken
	task automatic offer(input logic [31:0] w, input bit lst, input bit pinned,
			input vtgd_pkg::result_t r);
		int unsigned gap;
		pin_t        p;
		if (burst_left != 0) begin
			gap = 0;
			burst_left--;
		end else begin
			if ($urandom_range(0, 39) == 0)
				burst_left = $urandom_range(30, 100);
			gap = idle_len();
		end
		if (gap != 0) begin
			push <= 1'b0;
			item <= '{word: $urandom, last_word: 1'($urandom)};
			repeat (gap) @(posedge clk);
		end
		p.pinned = pinned;
		p.r = r;
		pinned_q.push_back(p);
		push <= 1'b1;
		item <= '{word: w, last_word: lst};
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
		if (sent == 300)
			hold_req = 1;
	endtask

	// One geometry list: mostly well formed, some cut short
	task automatic send_list();
		logic [31:0] words[$];
		int unsigned ncmd;
		int unsigned r;
		int unsigned npar;
		logic [2:0]  id;
		logic [28:0] cnt;
		bit          stop;
		stop = 0;
		ncmd = $urandom_range(1, 6);
		for (int c = 0; c < ncmd && !stop; c++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				id = r[0] ? vtgd_pkg::CMD_MOVE : vtgd_pkg::CMD_LINE;
			else
				id = 3'($urandom_range(0, 7));
			cnt = 29'($urandom_range(0, 4));
			npar = 2 * cnt;
			// huge count: a few parameters, then the list ends
			if ($urandom_range(0, 19) == 0) begin
				cnt = 29'($urandom);
				npar = $urandom_range(0, 6);
				stop = 1;
			end
			words.push_back({cnt, id});
			if (id == vtgd_pkg::CMD_MOVE || id == vtgd_pkg::CMD_LINE)
				repeat (npar) words.push_back(param_word());
		end
		if ($urandom_range(0, 99) < 15)
			words = words[0:$urandom_range(0, words.size() - 1)];
		foreach (words[i])
			offer(words[i], i == words.size() - 1, 0, '0);
	endtask

	// Stimulus
	initial begin
		add_row(32'h0000_0000, 0, 1, vtgd_pkg::KIND_HEADER, 3'd0, 29'd0);
		add_row(32'hFFFF_FFFF, 0, 1, vtgd_pkg::KIND_HEADER, 3'd7, 29'h1FFF_FFFF);
		add_row({29'd5, 3'd3}, 0, 1, vtgd_pkg::KIND_HEADER, 3'd3, 29'd5);
		add_row({29'd1, 3'd4}, 0, 1, vtgd_pkg::KIND_HEADER, 3'd4, 29'd1);
		add_row({29'd2, 3'd5}, 0, 1, vtgd_pkg::KIND_HEADER, 3'd5, 29'd2);
		add_row({29'd3, 3'd6}, 0, 1, vtgd_pkg::KIND_HEADER, 3'd6, 29'd3);
		add_row({29'd0, vtgd_pkg::CMD_MOVE}, 0, 1,
			vtgd_pkg::KIND_HEADER, vtgd_pkg::CMD_MOVE, 29'd0);
		add_row({29'd0, vtgd_pkg::CMD_LINE}, 0, 1,
			vtgd_pkg::KIND_HEADER, vtgd_pkg::CMD_LINE, 29'd0);
		add_row({29'd2, vtgd_pkg::CMD_MOVE}, 0, 1,
			vtgd_pkg::KIND_HEADER, vtgd_pkg::CMD_MOVE, 29'd2);
		add_row(32'hFFFF_FFFF, 0, 0, vtgd_pkg::KIND_POINT, 3'd0, 29'd0);
		add_row(32'hFFFF_FFFE, 0, 0, vtgd_pkg::KIND_POINT, 3'd0, 29'd0);
		add_row(32'h0000_0000, 0, 0, vtgd_pkg::KIND_POINT, 3'd0, 29'd0);
		add_row(32'h0000_0001, 0, 0, vtgd_pkg::KIND_POINT, 3'd0, 29'd0);
		add_row({29'h1FFF_FFFF, vtgd_pkg::CMD_LINE}, 0, 1,
			vtgd_pkg::KIND_HEADER, vtgd_pkg::CMD_LINE, 29'h1FFF_FFFF);
		add_row(32'h0000_0002, 0, 0, vtgd_pkg::KIND_POINT, 3'd0, 29'd0);
		add_row(32'h0000_0003, 0, 0, vtgd_pkg::KIND_POINT, 3'd0, 29'd0);
		// list ends on an x word: truncation without a point
		add_row(32'h0000_0005, 1, 1,
			vtgd_pkg::KIND_TRUNC, vtgd_pkg::CMD_LINE, 29'h1FFF_FFFE);
		add_row({29'd3, vtgd_pkg::CMD_LINE}, 0, 1,
			vtgd_pkg::KIND_HEADER, vtgd_pkg::CMD_LINE, 29'd3);
		add_row(32'h8000_0000, 0, 0, vtgd_pkg::KIND_POINT, 3'd0, 29'd0);
		add_row(32'h7FFF_FFFF, 1, 0, vtgd_pkg::KIND_POINT, 3'd0, 29'd0);
		// list ends on a header that needs parameters
		add_row({29'd1, vtgd_pkg::CMD_MOVE}, 1, 1,
			vtgd_pkg::KIND_TRUNC, vtgd_pkg::CMD_MOVE, 29'd1);
		add_row({29'd1, vtgd_pkg::CMD_MOVE}, 0, 1,
			vtgd_pkg::KIND_HEADER, vtgd_pkg::CMD_MOVE, 29'd1);
		add_row(32'h0000_0010, 0, 0, vtgd_pkg::KIND_POINT, 3'd0, 29'd0);
		add_row(32'h0000_0011, 1, 0, vtgd_pkg::KIND_POINT, 3'd0, 29'd0);
		add_row({29'd9, 3'd7}, 1, 1, vtgd_pkg::KIND_HEADER, 3'd7, 29'd9);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer(plan[i].w, plan[i].lst, plan[i].pinned, plan[i].r);

		while (sent < plan.size() + N_RANDOM) begin
			if ($urandom_range(0, 9) == 0)
				offer($urandom, $urandom_range(0, 3) == 0, 0, '0);
			else
				send_list();
		end
		push <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_LEN) @(posedge clk);
		if (fail_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Result side: random pop stretches and one long hold-off
	initial begin
		int unsigned lo;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				pop <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_done = 1;
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 120 : 12))
					@(posedge clk);
				lo = idle_len();
				if (lo != 0) begin
					pop <= 1'b0;
					repeat (lo) @(posedge clk);
				end
			end
		end
	end

	// Scoreboard: predict on each accepted word, compare each popped result
	vtgd_pkg::result_t predicted;
	vtgd_pkg::result_t wanted;
	pin_t              pin;

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				pin = pinned_q.pop_front();
				if (decode_word(item, predicted))
					pending_results.push_back(pin.pinned ? pin.r : predicted);
			end
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORT)
						$display("unexpected result word: kind=%0d id=%0d cnt=%0d x=%0d y=%0d",
							result.kind, result.cmd_id, result.repeat_count,
							result.point_x, result.point_y);
				end else begin
					wanted = pending_results.pop_front();
					if (result.kind !== wanted.kind || result.cmd_id !== wanted.cmd_id
							|| result.repeat_count !== wanted.repeat_count
							|| result.point_x !== wanted.point_x
							|| result.point_y !== wanted.point_y) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORT)
							$display({"mismatch: expected kind=%0d id=%0d cnt=%0d x=%0d y=%0d",
								", got kind=%0d id=%0d cnt=%0d x=%0d y=%0d"},
								wanted.kind, wanted.cmd_id, wanted.repeat_count,
								wanted.point_x, wanted.point_y,
								result.kind, result.cmd_id, result.repeat_count,
								result.point_x, result.point_y);
					end
				end
			end
		end
	end

	initial clear_decoder();

endmodule

// ===== vector_tile_geometry_decoder.f =====
hdl/vtgd_pkg.sv
hdl/vtgd_front.sv
hdl/vtgd_queue.sv
hdl/vtgd_back.sv
hdl/vector_tile_geometry_decoder.sv
tb/tb_vector_tile_geometry_decoder.sv
